/* rtl/set_assoc_lru_cache_tags_macros.svh */
// Assertion macros for the set-associative LRU tag store.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define SACT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SACT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sact_pkg.sv */
// Shared constants and types of the set-associative LRU tag store.
// Used by sact_ctrl, sact_dp and set_assoc_lru_cache_tags; no dependencies.
package sact_pkg;

  localparam int ADDR_W = 32;
  localparam int TAG_W  = 29;
  localparam int CNT_W  = 32;
  localparam int NUM_CNT = 5;

  // Default geometry
  localparam int DEF_MAX_WAYS       = 4;
  localparam int DEF_MAX_INDEX_BITS = 8;
  localparam int DEF_AGE_BITS       = 16;

  // Configuration register file
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX  = 2'd2;

  localparam logic [2:0] WAYS_RST   = 3'd1;
  localparam logic [2:0] OFFSET_RST = 3'd4;
  localparam logic [3:0] INDEX_RST  = 4'd8;
  localparam logic [2:0] OFFSET_MIN = 3'd2;
  localparam logic [2:0] OFFSET_MAX = 3'd6;

  // Event counter slots
  localparam int CNT_DIRTY_EVICT = 0;
  localparam int CNT_LOAD_MISS   = 1;
  localparam int CNT_STORE_MISS  = 2;
  localparam int CNT_LOAD_HIT    = 3;
  localparam int CNT_STORE_HIT   = 4;

  typedef struct packed {
    logic accept;
    logic clear;
    logic lookup;
    logic scan;
    logic write;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic hit;
    logic one_way;
    logic scan_last;
  } status_t;

endpackage

/* rtl/sact_ctrl.sv */
// Controller of the LRU tag store: clearing pass, lookup, victim scan, write-back.
// Depends on sact_pkg and set_assoc_lru_cache_tags_macros.svh.
`include "set_assoc_lru_cache_tags_macros.svh"

module sact_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output sact_pkg::cmd_t    cmd,
  input  sact_pkg::status_t status
);
  import sact_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN,
    ST_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.accept = (state_r == ST_IDLE) && start;
    cmd.clear  = (state_r == ST_CLEAR);
    cmd.lookup = (state_r == ST_LOOKUP);
    cmd.scan   = (state_r == ST_SCAN);
    cmd.write  = (state_r == ST_WRITE);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_LOOKUP;
      end
      ST_LOOKUP: begin
        if (status.hit || status.one_way) state_nxt = ST_WRITE;
        else state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_last) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != ST_IDLE);
      out_valid_r <= (state_r == ST_WRITE);
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

  `SACT_ASSERT_IMP(a_strobe_when_idle, out_valid, !busy, "result strobe while busy")
  `SACT_ASSERT_NXT(a_accept_goes_busy, start && !busy, busy && !out_valid, "accept did not start work")
  `SACT_ASSERT_IMP(a_scan_needs_ways, state_r == ST_SCAN, !status.one_way, "victim scan with one way")
  `SACT_ASSERT_NXT(a_write_strobes, state_r == ST_WRITE, out_valid, "write-back without strobe")

endmodule

/* rtl/sact_dp.sv */
// Datapath of the LRU tag store: configuration, address split, set memories,
// hit detection, victim scan, row update and event counters. Depends on sact_pkg.
module sact_dp #(
  parameter int MAX_WAYS       = sact_pkg::DEF_MAX_WAYS,
  parameter int MAX_INDEX_BITS = sact_pkg::DEF_MAX_INDEX_BITS,
  parameter int AGE_BITS       = sact_pkg::DEF_AGE_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sact_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sact_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic [sact_pkg::ADDR_W-1:0]      in_address,
  input  logic                             in_is_store,
  input  sact_pkg::cmd_t                   cmd,
  output sact_pkg::status_t                status,
  output logic                             out_hit,
  output logic                             out_dirty_eviction,
  output logic [1:0]                       out_way_used,
  output logic [sact_pkg::CNT_W-1:0]       out_dirty_evictions_total,
  output logic [sact_pkg::CNT_W-1:0]       out_load_misses_total,
  output logic [sact_pkg::CNT_W-1:0]       out_store_misses_total,
  output logic [sact_pkg::CNT_W-1:0]       out_load_hits_total,
  output logic [sact_pkg::CNT_W-1:0]       out_store_hits_total
);
  import sact_pkg::*;

  localparam int ROWS  = 1 << MAX_INDEX_BITS;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int NW_W  = $clog2(MAX_WAYS + 1);
  localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

  // Configuration
  logic [2:0] ways_r, offset_r;
  logic [3:0] index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ways_r   <= WAYS_RST;
      offset_r <= OFFSET_RST;
      index_r  <= INDEX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WAYS:   ways_r   <= cfg_wdata[2:0];
        REG_OFFSET: offset_r <= cfg_wdata[2:0];
        REG_INDEX:  index_r  <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers into their working ranges
  logic [NW_W-1:0] nways;
  logic [2:0]      ob;
  logic [3:0]      ib;

  always_comb begin
    if (ways_r == 3'd0) nways = NW_W'(1);
    else if (int'(ways_r) > MAX_WAYS) nways = NW_W'(MAX_WAYS);
    else nways = NW_W'(ways_r);

    if (offset_r < OFFSET_MIN) ob = OFFSET_MIN;
    else if (offset_r > OFFSET_MAX) ob = OFFSET_MAX;
    else ob = offset_r;

    if (index_r == 4'd0) ib = 4'd1;
    else if (int'(index_r) > MAX_INDEX_BITS) ib = 4'(MAX_INDEX_BITS);
    else ib = index_r;
  end

  // Address split
  logic [ADDR_W-1:0]         addr_sh, tag_full;
  logic [MAX_INDEX_BITS-1:0] set_mask, set_in;
  logic [TAG_W-1:0]          tag_in;

  always_comb begin
    addr_sh  = in_address >> ob;
    tag_full = in_address >> (5'(ob) + 5'(ib));
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      set_mask[i] = (i < int'(ib));
    end
    set_in = addr_sh[MAX_INDEX_BITS-1:0] & set_mask;
    tag_in = tag_full[TAG_W-1:0];
  end

  // Set memories, one row per set
  logic [MAX_WAYS-1:0]                mem_valid [ROWS];
  logic [MAX_WAYS-1:0]                mem_dirty [ROWS];
  logic [MAX_WAYS-1:0][TAG_W-1:0]     mem_tag   [ROWS];
  logic [MAX_WAYS-1:0][AGE_BITS-1:0]  mem_age   [ROWS];

  logic [MAX_WAYS-1:0]                valid_q, dirty_q;
  logic [MAX_WAYS-1:0][TAG_W-1:0]     tag_q;
  logic [MAX_WAYS-1:0][AGE_BITS-1:0]  age_q;

  logic [MAX_WAYS-1:0]                valid_new, dirty_new;
  logic [MAX_WAYS-1:0][TAG_W-1:0]     tag_new;
  logic [MAX_WAYS-1:0][AGE_BITS-1:0]  age_new;

  logic [MAX_INDEX_BITS-1:0] set_r, clr_r;
  logic [TAG_W-1:0]          tag_r;
  logic                      store_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      valid_q <= mem_valid[set_in];
      dirty_q <= mem_dirty[set_in];
      tag_q   <= mem_tag[set_in];
      age_q   <= mem_age[set_in];
    end
    if (cmd.clear) begin
      mem_valid[clr_r] <= '0;
      mem_dirty[clr_r] <= '0;
      mem_tag[clr_r]   <= '0;
      mem_age[clr_r]   <= '0;
    end else if (cmd.write) begin
      mem_valid[set_r] <= valid_new;
      mem_dirty[set_r] <= dirty_new;
      mem_tag[set_r]   <= tag_new;
      mem_age[set_r]   <= age_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      set_r   <= set_in;
      tag_r   <= tag_in;
      store_r <= in_is_store;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clear) clr_r <= clr_r + 1'b1;
  end

  // Hit detection: lowest matching way in use wins
  logic             hit;
  logic [WAY_W-1:0] hit_way;

  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if ((w < int'(nways)) && valid_q[w] && (tag_q[w] == tag_r)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
    end
  end

  // Lookup registers the hit; the victim scan checks one way per cycle
  logic                hit_r;
  logic [WAY_W-1:0]    used_r, scan_r;
  logic [AGE_BITS-1:0] best_age_r;

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit_r      <= hit;
      used_r     <= hit ? hit_way : '0;
      best_age_r <= age_q[0];
      scan_r     <= WAY_W'(1);
    end else if (cmd.scan) begin
      // strictly greater keeps the lowest way on ties
      if (age_q[scan_r] > best_age_r) begin
        used_r     <= scan_r;
        best_age_r <= age_q[scan_r];
      end
      scan_r <= scan_r + 1'b1;
    end
  end

  assign status.clear_last = &clr_r;
  assign status.hit        = hit;
  assign status.one_way    = (nways == NW_W'(1));
  assign status.scan_last  = (NW_W'(scan_r) == (nways - NW_W'(1)));

  // Row update
  logic evict;

  always_comb begin
    evict = !hit_r && dirty_q[used_r];
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (used_r == WAY_W'(w)) begin
        valid_new[w] = 1'b1;
        tag_new[w]   = hit_r ? tag_q[w] : tag_r;
        dirty_new[w] = store_r | (hit_r & dirty_q[w]);
        age_new[w]   = '0;
      end else begin
        valid_new[w] = valid_q[w];
        tag_new[w]   = tag_q[w];
        dirty_new[w] = dirty_q[w];
        if ((w < int'(nways)) && (age_q[w] != AGE_MAX)) age_new[w] = age_q[w] + 1'b1;
        else age_new[w] = age_q[w];
      end
    end
  end

  // Result and event counters
  logic                hit_out_r, evict_out_r;
  logic [1:0]          way_out_r;
  logic [CNT_W-1:0]    cnt_r [NUM_CNT];
  logic [NUM_CNT-1:0]  cnt_inc;

  always_comb begin
    cnt_inc                  = '0;
    cnt_inc[CNT_DIRTY_EVICT] = evict;
    cnt_inc[CNT_LOAD_MISS]   = !hit_r && !store_r;
    cnt_inc[CNT_STORE_MISS]  = !hit_r && store_r;
    cnt_inc[CNT_LOAD_HIT]    = hit_r && !store_r;
    cnt_inc[CNT_STORE_HIT]   = hit_r && store_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.write) begin
      hit_out_r   <= hit_r;
      evict_out_r <= evict;
      way_out_r   <= 2'(used_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_CNT; k++) cnt_r[k] <= '0;
    end else if (cmd.write) begin
      for (int k = 0; k < NUM_CNT; k++) begin
        if (cnt_inc[k] && (cnt_r[k] != {CNT_W{1'b1}})) cnt_r[k] <= cnt_r[k] + 1'b1;
      end
    end
  end

  assign out_hit                   = hit_out_r;
  assign out_dirty_eviction        = evict_out_r;
  assign out_way_used              = way_out_r;
  assign out_dirty_evictions_total = cnt_r[CNT_DIRTY_EVICT];
  assign out_load_misses_total     = cnt_r[CNT_LOAD_MISS];
  assign out_store_misses_total    = cnt_r[CNT_STORE_MISS];
  assign out_load_hits_total       = cnt_r[CNT_LOAD_HIT];
  assign out_store_hits_total      = cnt_r[CNT_STORE_HIT];

endmodule

/* rtl/set_assoc_lru_cache_tags.sv */
// Top level of the set-associative write-back cache tag store with age-based LRU.
// Depends on sact_pkg, sact_ctrl and sact_dp.
//
// Input: present in_address and in_is_store with start; the access is taken at
// a rising edge where start is high and busy is low.
// Result: out_valid is high for exactly one cycle with hit, dirty eviction,
// way used and the five event counters after this access. The receiver cannot
// stall; the result must be taken in that cycle.
// Sequence: the accepting edge enters lookup; a hit, or a miss with a single way
// in use, goes straight on to write-back; any other miss first runs the victim
// scan, stepping through the ways in use beyond the first, one way per cycle. busy
// drops in the same cycle as out_valid, so the next access can be taken there.
// Reset: the set memories are cleared one set per cycle, all 2**MAX_INDEX_BITS
// sets, with busy held high; configuration writes are taken throughout.
// Configuration: cfg_we with cfg_index (0 ways in use, 1 offset bits,
// 2 index bits) and cfg_wdata; write only while no access is outstanding.
module set_assoc_lru_cache_tags #(
  parameter int MAX_WAYS       = sact_pkg::DEF_MAX_WAYS,
  parameter int MAX_INDEX_BITS = sact_pkg::DEF_MAX_INDEX_BITS,
  parameter int AGE_BITS       = sact_pkg::DEF_AGE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [sact_pkg::ADDR_W-1:0]     in_address,
  input  logic                            in_is_store,
  output logic                            out_valid,
  output logic                            out_hit,
  output logic                            out_dirty_eviction,
  output logic [1:0]                      out_way_used,
  output logic [sact_pkg::CNT_W-1:0]      out_dirty_evictions_total,
  output logic [sact_pkg::CNT_W-1:0]      out_load_misses_total,
  output logic [sact_pkg::CNT_W-1:0]      out_store_misses_total,
  output logic [sact_pkg::CNT_W-1:0]      out_load_hits_total,
  output logic [sact_pkg::CNT_W-1:0]      out_store_hits_total,
  input  logic                            cfg_we,
  input  logic [sact_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sact_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sact_pkg::*;

  cmd_t    cmd;
  status_t status;

  sact_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .status    (status)
  );

  sact_dp #(
    .MAX_WAYS       (MAX_WAYS),
    .MAX_INDEX_BITS (MAX_INDEX_BITS),
    .AGE_BITS       (AGE_BITS)
  ) u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .in_address                (in_address),
    .in_is_store               (in_is_store),
    .cmd                       (cmd),
    .status                    (status),
    .out_hit                   (out_hit),
    .out_dirty_eviction        (out_dirty_eviction),
    .out_way_used              (out_way_used),
    .out_dirty_evictions_total (out_dirty_evictions_total),
    .out_load_misses_total     (out_load_misses_total),
    .out_store_misses_total    (out_store_misses_total),
    .out_load_hits_total       (out_load_hits_total),
    .out_store_hits_total      (out_store_hits_total)
  );

endmodule

/* dv/set_assoc_lru_cache_tags_tb.sv */
// Self-checking testbench for the set-associative LRU tag store set_assoc_lru_cache_tags.
// Holds its own model of the tag, valid, dirty and age arrays and the event counters.
// Depends on sact_pkg and the RTL of set_assoc_lru_cache_tags only.
module set_assoc_lru_cache_tags_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sact_pkg::*;

  localparam int WAYS_MAX   = DEF_MAX_WAYS;
  localparam int IDX_MAX    = DEF_MAX_INDEX_BITS;
  // Narrow ages so the saturation case is reached in a few accesses
  localparam int AGE_W      = 4;
  localparam int LINES      = WAYS_MAX << IDX_MAX;
  localparam int IDLE_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic             hit;
    logic             dirty_eviction;
    logic [1:0]       way_used;
    logic [CNT_W-1:0] dirty_evictions_total;
    logic [CNT_W-1:0] load_misses_total;
    logic [CNT_W-1:0] store_misses_total;
    logic [CNT_W-1:0] load_hits_total;
    logic [CNT_W-1:0] store_hits_total;
  } access_result_t;

  logic                  clk;
  logic                  rst_n       = 1'b0;
  logic                  start       = 1'b0;
  logic                  busy;
  logic [ADDR_W-1:0]     in_address  = '0;
  logic                  in_is_store = 1'b0;
  logic                  out_valid;
  logic                  out_hit;
  logic                  out_dirty_eviction;
  logic [1:0]            out_way_used;
  logic [CNT_W-1:0]      out_dirty_evictions_total;
  logic [CNT_W-1:0]      out_load_misses_total;
  logic [CNT_W-1:0]      out_store_misses_total;
  logic [CNT_W-1:0]      out_load_hits_total;
  logic [CNT_W-1:0]      out_store_hits_total;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  // Model state
  logic [2:0]              ways_reg;
  logic [2:0]              offset_reg;
  logic [3:0]              index_reg;
  logic                    way_valid [LINES];
  logic                    way_dirty [LINES];
  logic [TAG_W-1:0]        way_tag   [LINES];
  logic [AGE_W-1:0]        way_age   [LINES];
  logic [CNT_W-1:0]        event_total [NUM_CNT];

  access_result_t pending_results[$];
  access_result_t head;
  int             errors      = 0;
  int             n_sent      = 0;
  int             n_checked   = 0;
  int             n_hits      = 0;
  int             n_evictions = 0;
  int             n_settings  = 0;
  int             idle_cycles = 0;

  set_assoc_lru_cache_tags #(
    .AGE_BITS (AGE_W)
  ) u_top (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .start                    (start),
    .busy                     (busy),
    .in_address               (in_address),
    .in_is_store              (in_is_store),
    .out_valid                (out_valid),
    .out_hit                  (out_hit),
    .out_dirty_eviction       (out_dirty_eviction),
    .out_way_used             (out_way_used),
    .out_dirty_evictions_total(out_dirty_evictions_total),
    .out_load_misses_total    (out_load_misses_total),
    .out_store_misses_total   (out_store_misses_total),
    .out_load_hits_total      (out_load_hits_total),
    .out_store_hits_total     (out_store_hits_total),
    .cfg_we                   (cfg_we),
    .cfg_index                (cfg_index),
    .cfg_wdata                (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Effective geometry: out-of-range register values saturate
  function automatic int unsigned ways_eff();
    if (ways_reg == 0) return 1;
    if (ways_reg > WAYS_MAX) return WAYS_MAX;
    return ways_reg;
  endfunction

  function automatic int unsigned offset_eff();
    if (offset_reg < OFFSET_MIN) return OFFSET_MIN;
    if (offset_reg > OFFSET_MAX) return OFFSET_MAX;
    return offset_reg;
  endfunction

  function automatic int unsigned index_eff();
    if (index_reg == 0) return 1;
    if (index_reg > IDX_MAX) return IDX_MAX;
    return index_reg;
  endfunction

  function automatic logic [ADDR_W-1:0] pack_addr(logic [31:0] tg, logic [31:0] set_no,
                                                  logic [31:0] low);
    int unsigned ob;
    int unsigned ib;
    ob = offset_eff();
    ib = index_eff();
    return (tg << (ob + ib)) | ((set_no & ((32'd1 << ib) - 1)) << ob) |
           (low & ((32'd1 << ob) - 1));
  endfunction

  function automatic void bump_event(int k);
    if (event_total[k] != '1) event_total[k] = event_total[k] + 1;
  endfunction

  // Look up, replace and age one set; returns what the block should report
  function automatic access_result_t predict_lookup(logic [ADDR_W-1:0] addr, logic st);
    int unsigned    nw;
    int unsigned    ob;
    int unsigned    ib;
    int unsigned    base;
    int unsigned    used;
    logic [TAG_W-1:0] tg;
    logic           found;
    access_result_t r;
    nw    = ways_eff();
    ob    = offset_eff();
    ib    = index_eff();
    base  = ((addr >> ob) & ((32'd1 << ib) - 1)) * WAYS_MAX;
    tg    = TAG_W'(addr >> (ob + ib));
    found = 1'b0;
    used  = 0;
    r     = '0;
    for (int w = 0; w < nw; w++) begin
      if (!found && way_valid[base + w] && way_tag[base + w] == tg) begin
        found = 1'b1;
        used  = w;
      end
    end
    r.hit = found;
    if (found) begin
      bump_event(st ? CNT_STORE_HIT : CNT_LOAD_HIT);
    end else begin
      bump_event(st ? CNT_STORE_MISS : CNT_LOAD_MISS);
      for (int w = 1; w < nw; w++)
        if (way_age[base + w] > way_age[base + used]) used = w;
      way_tag[base + used]   = tg;
      way_valid[base + used] = 1'b1;
      if (way_dirty[base + used]) begin
        r.dirty_eviction       = 1'b1;
        bump_event(CNT_DIRTY_EVICT);
        way_dirty[base + used] = 1'b0;
      end
    end
    for (int w = 0; w < nw; w++)
      if (way_age[base + w] != '1) way_age[base + w] = way_age[base + w] + 1'b1;
    way_age[base + used] = '0;
    if (st) way_dirty[base + used] = 1'b1;
    r.way_used              = 2'(used);
    r.dirty_evictions_total = event_total[CNT_DIRTY_EVICT];
    r.load_misses_total     = event_total[CNT_LOAD_MISS];
    r.store_misses_total    = event_total[CNT_STORE_MISS];
    r.load_hits_total       = event_total[CNT_LOAD_HIT];
    r.store_hits_total      = event_total[CNT_STORE_HIT];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s differs, expected %0h, actual %0h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Send one access; hold start high when the next one follows without a gap
  task automatic send_access(logic [ADDR_W-1:0] addr, logic st, int gap_max);
    int gap;
    gap = $urandom_range(gap_max, 0);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    in_address  <= addr;
    in_is_store <= st;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_lookup(addr, st));
    n_sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_WAYS:   ways_reg   = val[2:0];
      REG_OFFSET: offset_reg = val[2:0];
      REG_INDEX:  index_reg  = val;
      default: ;
    endcase
  endtask

  task automatic set_geometry(logic [3:0] ways, logic [3:0] offs, logic [3:0] idx);
    wait_idle();
    write_reg(REG_WAYS, ways);
    write_reg(REG_OFFSET, offs);
    write_reg(REG_INDEX, idx);
    n_settings++;
  endtask

  // Hits, misses and dirty evictions with the reset geometry (one way)
  task automatic test_reset_geometry();
    send_access(32'h0000_0000, 1'b0, 5);
    send_access(32'h0000_000F, 1'b0, 5);
    send_access(32'hFFFF_FFFF, 1'b1, 5);
    send_access(32'hFFFF_FFF0, 1'b1, 5);
    // store miss over a dirty line: evicted, then dirty again
    send_access(32'h7FFF_FFF0, 1'b1, 5);
    send_access(32'hFFFF_FFFF, 1'b0, 5);
  endtask

  task automatic test_lru_replacement();
    set_geometry(4'd4, 4'd2, 4'd1);
    for (int t = 1; t <= 4; t++) send_access(pack_addr(t, 1, 0), 1'b0, 5);
    send_access(pack_addr(2, 1, 3), 1'b1, 5);
    send_access(pack_addr(5, 1, 0), 1'b0, 5);
    send_access(pack_addr(3, 1, 1), 1'b0, 5);
    send_access(pack_addr(6, 1, 2), 1'b1, 5);
    send_access(pack_addr(7, 1, 0), 1'b0, 5);
  endtask

  // Shrink the ways in use so one tag lands in two ways, then look it up
  task automatic test_duplicate_tags();
    set_geometry(4'd2, 4'd2, 4'd1);
    send_access(pack_addr(7, 0, 0), 1'b0, 5);
    send_access(pack_addr(8, 0, 0), 1'b1, 5);
    wait_idle();
    write_reg(REG_WAYS, 4'd1);
    send_access(pack_addr(8, 0, 0), 1'b0, 5);
    wait_idle();
    write_reg(REG_WAYS, 4'd2);
    send_access(pack_addr(8, 0, 0), 1'b1, 5);
  endtask

  // Hammer one way until the other two ages sit at all ones, then miss on a tie
  task automatic test_age_saturation();
    set_geometry(4'd3, 4'd2, 4'd2);
    for (int t = 100; t <= 102; t++) send_access(pack_addr(t, 3, 0), 1'b0, 0);
    for (int i = 0; i < 20; i++) send_access(pack_addr(102, 3, 0), i[0], 0);
    send_access(pack_addr(103, 3, 0), 1'b0, 0);
    send_access(pack_addr(104, 3, 0), 1'b1, 3);
    send_access(pack_addr(105, 3, 0), 1'b0, 3);
  endtask

  task automatic test_register_extremes();
    logic [ADDR_W-1:0] a;
    set_geometry(4'd0, 4'd0, 4'd0);
    a = $urandom;
    send_access(a, 1'b1, 5);
    send_access(a, 1'b0, 5);
    send_access(~a, 1'b0, 5);
    set_geometry(4'd15, 4'd15, 4'd15);
    a = $urandom;
    send_access(a, 1'b0, 5);
    send_access(a, 1'b1, 5);
    send_access(a ^ 32'h8000_0000, 1'b0, 5);
    set_geometry(4'd5, 4'd1, 4'd9);
    send_access(a, 1'b0, 5);
    send_access(a, 1'b1, 5);
    // unused register index: nothing should change
    wait_idle();
    write_reg(REG_SPARE, 4'hF);
    send_access(a, 1'b0, 5);
  endtask

  task automatic test_random_traffic();
    logic [31:0]       tag_pool [5];
    logic [31:0]       set_pool [3];
    logic [ADDR_W-1:0] a;
    int                gap_max;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       set_geometry(4'd4, 4'd2, 4'd1);
        1:       set_geometry(4'd1, 4'd6, 4'd8);
        2:       set_geometry(4'd4, 4'd6, 4'd8);
        3:       set_geometry(4'd2, 4'd2, 4'd8);
        default: set_geometry(4'($urandom_range(15, 0)), 4'($urandom_range(15, 0)),
                              4'($urandom_range(15, 0)));
      endcase
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      foreach (set_pool[i]) set_pool[i] = $urandom;
      gap_max = (p % 3 == 0) ? 0 : 5;
      for (int i = 0; i < 125; i++) begin
        // mostly reuse a few lines so hits and evictions recur; the rest is noise
        if ($urandom_range(99, 0) < 85)
          a = pack_addr(tag_pool[$urandom_range(4, 0)], set_pool[$urandom_range(2, 0)],
                        $urandom);
        else
          a = $urandom;
        send_access(a, 1'($urandom_range(1, 0)), gap_max);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no access outstanding, expected none, actual way %0d",
                 $time, out_way_used);
        errors++;
      end else begin
        head = pending_results.pop_front();
        check_field("hit", head.hit, out_hit);
        check_field("dirty_eviction", head.dirty_eviction, out_dirty_eviction);
        check_field("way_used", head.way_used, out_way_used);
        check_field("dirty_evictions_total", head.dirty_evictions_total,
                    out_dirty_evictions_total);
        check_field("load_misses_total", head.load_misses_total, out_load_misses_total);
        check_field("store_misses_total", head.store_misses_total, out_store_misses_total);
        check_field("load_hits_total", head.load_hits_total, out_load_hits_total);
        check_field("store_hits_total", head.store_hits_total, out_store_hits_total);
        n_checked++;
        n_hits      += head.hit;
        n_evictions += head.dirty_eviction;
      end
    end
  end

  // Drop out when no transaction moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding",
               $time, IDLE_LIMIT, pending_results.size());
      $display("set_assoc_lru_cache_tags: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    ways_reg   = WAYS_RST;
    offset_reg = OFFSET_RST;
    index_reg  = INDEX_RST;
    for (int i = 0; i < LINES; i++) begin
      way_valid[i] = 1'b0;
      way_dirty[i] = 1'b0;
      way_tag[i]   = '0;
      way_age[i]   = '0;
    end
    foreach (event_total[k]) event_total[k] = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_geometry();
    test_lru_replacement();
    test_duplicate_tags();
    test_age_saturation();
    test_register_extremes();
    test_random_traffic();

    wait_idle();
    repeat (10) @(posedge clk);
    $display("Ran %0d accesses, %0d results checked: %0d hits, %0d dirty evictions,",
             n_sent, n_checked, n_hits, n_evictions);
    $display("over %0d geometries incl. out-of-range registers, duplicate tags, age limit",
             n_settings + 1);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("set_assoc_lru_cache_tags: match");
    end else begin
      $display("set_assoc_lru_cache_tags: mismatch");
    end
    $finish;
  end

endmodule
